@@ design/bhpf_pkg.sv @@
`timescale 1ns / 1ps

package bhpf_pkg;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_B0 = 3'd0;
	localparam reg_idx_t REG_B1 = 3'd1;
	localparam reg_idx_t REG_B2 = 3'd2;
	localparam reg_idx_t REG_A1 = 3'd3;
	localparam reg_idx_t REG_A2 = 3'd4;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MB0  = 7'b0000010,
		ST_Y    = 7'b0000100,
		ST_N1A  = 7'b0001000,
		ST_N1B  = 7'b0010000,
		ST_N2A  = 7'b0100000,
		ST_N2B  = 7'b1000000
	} state_t;

endpackage

@@ design/biquad_highpass_filter.sv @@
`timescale 1ns / 1ps
// Biquad IIR filter, transposed direct form II, fixed point.
// s_axis carries one signed sample per word; m_axis returns one filtered,
// rounded and saturated sample per word. tdata holds the sample in its low
// SAMPLE_WIDTH bits, zero padded to whole bytes.
// Coefficients b0, b1, b2, a1, a2 sit at APB byte addresses 0, 4, 8, 12, 16
// as signed values with COEF_FRAC_BITS fractional bits. A coefficient write
// also clears both delay registers; write only while the filter is idle.
// All five products of a sample go one after another through a single
// registered multiplier under a seven-state sequencer. s_axis_tready is
// high only in the idle state, so a new sample is not accepted until the
// last one has left the sequencer.
// The output word sits in a register: a new sample is accepted while the
// last result waits, but the sequencer holds in its last step while
// m_axis stalls with a word still pending.
// Reset sets b0 to 1.0, the other coefficients and both delays to zero,
// and leaves no output word pending.
module biquad_highpass_filter #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bhpf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bhpf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bhpf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_in, rest zero
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_out, rest zero
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

	import bhpf_pkg::*;

	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int CW      = COEF_FRAC_BITS + 2;
	localparam int PW      = CW + SAMPLE_WIDTH;
	localparam int STW     = SAMPLE_WIDTH + COEF_FRAC_BITS + 6;
	localparam int ACC_W   = STW + 2;

	localparam logic signed [ACC_W-1:0] ST_MAX  = {{(ACC_W-STW+1){1'b0}}, {(STW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ST_MIN  = ~ST_MAX;
	localparam logic signed [ACC_W-1:0] SMP_MAX =
		{{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
	localparam logic signed [ACC_W-1:0] HALF    =
		{{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
	localparam logic signed [CW-1:0]    B0_RST  = {2'b01, {COEF_FRAC_BITS{1'b0}}};

	state_t state_q;

	logic signed [CW-1:0]           coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
	logic signed [STW-1:0]          delay_first_q, delay_second_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q, y_q, sample_out_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [STW-1:0]          n1_q;

	logic                           cfg_wr;
	reg_idx_t                       cfg_idx;
	logic                           out_busy;
	logic signed [CW-1:0]           mul_a;
	logic signed [SAMPLE_WIDTH-1:0] mul_b;
	logic signed [ACC_W-1:0]        acc_y, rnd_y, shr_y, diff;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic signed [STW-1:0]          diff_sat;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign cfg_idx  = paddr[APB_ADDR_W-1:2];
	assign out_busy = m_axis_tvalid & ~m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tdata  = {{(TDATA_W-SAMPLE_WIDTH){1'b0}}, sample_out_q};

	always_comb begin
		unique case (cfg_idx)
			REG_B0:  prdata = APB_DATA_W'(coef_b0_q);
			REG_B1:  prdata = APB_DATA_W'(coef_b1_q);
			REG_B2:  prdata = APB_DATA_W'(coef_b2_q);
			REG_A1:  prdata = APB_DATA_W'(coef_a1_q);
			REG_A2:  prdata = APB_DATA_W'(coef_a2_q);
			default: prdata = '0;
		endcase
	end

	// shared multiplier operand select; last step keeps a2*y while stalled
	always_comb begin
		unique case (state_q)
			ST_MB0:  begin mul_a = coef_b0_q; mul_b = x_q; end
			ST_Y:    begin mul_a = coef_b1_q; mul_b = x_q; end
			ST_N1A:  begin mul_a = coef_a1_q; mul_b = y_q; end
			ST_N1B:  begin mul_a = coef_b2_q; mul_b = x_q; end
			ST_N2A:  begin mul_a = coef_a2_q; mul_b = y_q; end
			ST_N2B:  begin mul_a = coef_a2_q; mul_b = y_q; end
			default: begin mul_a = coef_b0_q; mul_b = x_q; end
		endcase
	end

	// output: round half up, floor shift, saturate
	always_comb begin
		acc_y = ACC_W'(prod_q) + ACC_W'(delay_first_q);
		rnd_y = acc_y + HALF;
		shr_y = rnd_y >>> COEF_FRAC_BITS;
		if (shr_y > SMP_MAX) begin
			y_sat = SMP_MAX[SAMPLE_WIDTH-1:0];
		end else if (shr_y < SMP_MIN) begin
			y_sat = SMP_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y_sat = shr_y[SAMPLE_WIDTH-1:0];
		end
	end

	always_comb begin
		diff = acc_q - ACC_W'(prod_q);
		if (diff > ST_MAX) begin
			diff_sat = ST_MAX[STW-1:0];
		end else if (diff < ST_MIN) begin
			diff_sat = ST_MIN[STW-1:0];
		end else begin
			diff_sat = diff[STW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (s_axis_tvalid && s_axis_tready) begin
			x_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
		end
		if (state_q == ST_Y) begin
			y_q <= y_sat;
		end
		if (state_q == ST_N1A) begin
			acc_q <= ACC_W'(prod_q) + ACC_W'(delay_second_q);
		end else if (state_q == ST_N2A) begin
			acc_q <= ACC_W'(prod_q);
		end
		if (state_q == ST_N1B) begin
			n1_q <= diff_sat;
		end
		if (state_q == ST_N2B && !out_busy) begin
			sample_out_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			m_axis_tvalid  <= 1'b0;
			coef_b0_q      <= B0_RST;
			coef_b1_q      <= '0;
			coef_b2_q      <= '0;
			coef_a1_q      <= '0;
			coef_a2_q      <= '0;
			delay_first_q  <= '0;
			delay_second_q <= '0;
		end else begin
			if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_MB0;
					end
				end
				ST_MB0: state_q <= ST_Y;
				ST_Y:   state_q <= ST_N1A;
				ST_N1A: state_q <= ST_N1B;
				ST_N1B: state_q <= ST_N2A;
				ST_N2A: state_q <= ST_N2B;
				ST_N2B: begin
					if (!out_busy) begin
						delay_first_q  <= n1_q;
						delay_second_q <= diff_sat;
						m_axis_tvalid  <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_B0: begin
						coef_b0_q <= pwdata[CW-1:0];
						delay_first_q <= '0; delay_second_q <= '0;
					end
					REG_B1: begin
						coef_b1_q <= pwdata[CW-1:0];
						delay_first_q <= '0; delay_second_q <= '0;
					end
					REG_B2: begin
						coef_b2_q <= pwdata[CW-1:0];
						delay_first_q <= '0; delay_second_q <= '0;
					end
					REG_A1: begin
						coef_a1_q <= pwdata[CW-1:0];
						delay_first_q <= '0; delay_second_q <= '0;
					end
					REG_A2: begin
						coef_a2_q <= pwdata[CW-1:0];
						delay_first_q <= '0; delay_second_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == ST_MB0)
		else $error("accepted word did not start the sequencer");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready)
		else $error("ready while a sample is in work");

	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_N2B && !out_busy |=> state_q == ST_IDLE && m_axis_tvalid)
		else $error("last step did not hand over the result");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (cfg_idx == REG_B0 || cfg_idx == REG_A2) |=>
		delay_first_q == '0 && delay_second_q == '0)
		else $error("coefficient write left delays set");
`endif

endmodule
